// File: rtl/segment_line_intersection_core_macros.svh
// assertion macros shared by the intersection core
`ifndef SEGMENT_LINE_INTERSECTION_CORE_MACROS_SVH
`define SEGMENT_LINE_INTERSECTION_CORE_MACROS_SVH

// same-cycle implication
`define SLIC_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define SLIC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: rtl/slic_pkg.sv
// shared widths and the work record that flows through the divider cells
package slic_pkg;
  localparam int CW = 16;            // coordinate width
  localparam int DW = CW + 1;        // difference width
  localparam int PW = 2 * DW + 1;    // cross product width
  localparam int NW = PW + DW;       // scaled numerator width
  localparam int QB = CW + 1;        // quotient bits before overflow
  localparam int KW = $clog2(QB);    // cell bit index width
  localparam int VW = QB + 2;        // width of base plus quotient

  localparam logic [0:0] ADDR_SEGMENT_CHECK = 1'b0;

  typedef struct packed {
    logic [NW-1:0]        rx;
    logic [NW-1:0]        ry;
    logic [NW-1:0]        dm;
    logic [QB-1:0]        qx;
    logic [QB-1:0]        qy;
    logic                 nx;
    logic                 ny;
    logic                 ox;
    logic                 oy;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic                 hit;
    logic                 par;
  } slic_work_t;
endpackage

// File: rtl/slic_front.sv
// differences, cross products, segment test and division setup
module slic_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          seg_check,
  input  logic                          iv,
  output logic                          istall,
  input  logic signed [slic_pkg::CW-1:0] p0_x,
  input  logic signed [slic_pkg::CW-1:0] p0_y,
  input  logic signed [slic_pkg::CW-1:0] p1_x,
  input  logic signed [slic_pkg::CW-1:0] p1_y,
  input  logic signed [slic_pkg::CW-1:0] p2_x,
  input  logic signed [slic_pkg::CW-1:0] p2_y,
  input  logic signed [slic_pkg::CW-1:0] p3_x,
  input  logic signed [slic_pkg::CW-1:0] p3_y,
  output logic                          ov,
  output slic_pkg::slic_work_t          od,
  input  logic                          ostall
);
  import slic_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic a1, a2, a3, a4, a5;

  // stage 1 registers
  logic signed [DW-1:0] d1x, d1y, d2x, d2y, ex, ey;
  logic signed [CW-1:0] x0_1, y0_1;
  // stage 2 registers
  logic signed [2*DW-1:0] ma, mb, mc, md, me, mf;
  logic signed [DW-1:0] d1x_2, d1y_2;
  logic signed [CW-1:0] x0_2, y0_2;
  // stage 3 registers
  logic signed [PW-1:0] den, num1, num2;
  logic signed [DW-1:0] d1x_3, d1y_3;
  logic signed [CW-1:0] x0_3, y0_3;
  // stage 4 registers
  logic signed [NW-1:0] px, py;
  logic signed [PW-1:0] den_4;
  logic hit_4, par_4;
  logic signed [CW-1:0] x0_4, y0_4;

  logic signed [PW-1:0] den_next, num1_next, num2_next;
  logic hit_next;
  logic [NW-1:0] mx, my, dmag;
  logic [NW:0] lim;
  slic_work_t w_next;

  // stage advance chain, bubbles collapse
  assign a5 = !v5 || !ostall;
  assign a4 = !v4 || a5;
  assign a3 = !v3 || a4;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign istall = !a1;
  assign ov = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (a1) v1 <= iv;
      if (a2) v2 <= v1;
      if (a3) v3 <= v2;
      if (a4) v4 <= v3;
      if (a5) v5 <= v4;
    end
  end

  // stage 1: direction and offset vectors
  always_ff @(posedge clk) begin
    if (a1) begin
      d1x  <= DW'(p1_x) - DW'(p0_x);
      d1y  <= DW'(p1_y) - DW'(p0_y);
      d2x  <= DW'(p3_x) - DW'(p2_x);
      d2y  <= DW'(p3_y) - DW'(p2_y);
      ex   <= DW'(p0_x) - DW'(p2_x);
      ey   <= DW'(p0_y) - DW'(p2_y);
      x0_1 <= p0_x;
      y0_1 <= p0_y;
    end
  end

  // stage 2: six products
  always_ff @(posedge clk) begin
    if (a2) begin
      ma    <= d2y * d1x;
      mb    <= d2x * d1y;
      mc    <= d2x * ey;
      md    <= d2y * ex;
      me    <= d1x * ey;
      mf    <= d1y * ex;
      d1x_2 <= d1x;
      d1y_2 <= d1y;
      x0_2  <= x0_1;
      y0_2  <= y0_1;
    end
  end

  // stage 3: denominator and numerators
  always_comb begin
    den_next  = PW'(ma) - PW'(mb);
    num1_next = PW'(mc) - PW'(md);
    num2_next = PW'(me) - PW'(mf);
  end

  always_ff @(posedge clk) begin
    if (a3) begin
      den   <= den_next;
      num1  <= num1_next;
      num2  <= num2_next;
      d1x_3 <= d1x_2;
      d1y_3 <= d1y_2;
      x0_3  <= x0_2;
      y0_3  <= y0_2;
    end
  end

  // segment test by sign and magnitude
  always_comb begin
    if (!den[PW-1]) begin
      hit_next = !num1[PW-1] && (num1 <= den) && !num2[PW-1] && (num2 <= den);
    end else begin
      hit_next = (num1 <= 0) && (num1 >= den) && (num2 <= 0) && (num2 >= den);
    end
    hit_next = hit_next || !seg_check;
  end

  // stage 4: scaled numerators
  always_ff @(posedge clk) begin
    if (a4) begin
      px    <= num1 * d1x_3;
      py    <= num1 * d1y_3;
      den_4 <= den;
      hit_4 <= hit_next && (den != '0);
      par_4 <= (den == '0);
      x0_4  <= x0_3;
      y0_4  <= y0_3;
    end
  end

  // stage 5: magnitudes, signs and quotient overflow
  always_comb begin
    mx   = px[NW-1] ? NW'(-px) : NW'(px);
    my   = py[NW-1] ? NW'(-py) : NW'(py);
    dmag = den_4[PW-1] ? NW'(-den_4) : NW'(den_4);
    lim  = (NW+1)'(dmag) << QB;
    w_next.rx  = mx;
    w_next.ry  = my;
    w_next.dm  = dmag;
    w_next.qx  = '0;
    w_next.qy  = '0;
    w_next.nx  = px[NW-1] ^ den_4[PW-1];
    w_next.ny  = py[NW-1] ^ den_4[PW-1];
    w_next.ox  = {1'b0, mx} >= lim;
    w_next.oy  = {1'b0, my} >= lim;
    w_next.bx  = x0_4;
    w_next.by  = y0_4;
    w_next.hit = hit_4;
    w_next.par = par_4;
  end

  always_ff @(posedge clk) begin
    if (a5) od <= w_next;
  end
endmodule

// File: rtl/slic_cell.sv
// one restoring division step for both coordinates
module slic_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [slic_pkg::KW-1:0] k,
  input  logic                  iv,
  output logic                  istall,
  input  slic_pkg::slic_work_t  id,
  output logic                  ov,
  output slic_pkg::slic_work_t  od,
  input  logic                  ostall
);
  import slic_pkg::*;

  logic adv;
  logic [NW-1:0] dsh;
  logic tx, ty;
  slic_work_t w_next;

  assign adv = !ov || !ostall;
  assign istall = !adv;

  // trial subtract of the shifted divisor
  always_comb begin
    dsh = id.dm << k;
    tx  = id.rx >= dsh;
    ty  = id.ry >= dsh;
    w_next = id;
    if (tx) w_next.rx = id.rx - dsh;
    if (ty) w_next.ry = id.ry - dsh;
    w_next.qx[k] = tx;
    w_next.qy[k] = ty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= iv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) od <= w_next;
  end
endmodule

// File: rtl/slic_finish.sv
// signed quotient, add base point, clamp and result register
module slic_finish (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          iv,
  output logic                          istall,
  input  slic_pkg::slic_work_t          id,
  output logic                          ov,
  output logic signed [slic_pkg::CW-1:0] cx,
  output logic signed [slic_pkg::CW-1:0] cy,
  output logic                          hit,
  output logic                          par,
  output logic                          sat,
  input  logic                          ostall
);
  import slic_pkg::*;

  localparam logic signed [VW-1:0] MAXV = VW'((2 ** (CW - 1)) - 1);
  localparam logic signed [VW-1:0] MINV = -MAXV - VW'(1);

  logic adv;
  logic signed [VW-1:0] vx, vy;
  logic signed [CW-1:0] cx_next, cy_next;
  logic sx, sy;

  assign adv = !ov || !ostall;
  assign istall = !adv;

  // apply sign and add the base point for one coordinate
  function automatic logic signed [VW-1:0] place(input logic signed [CW-1:0] b,
                                                  input logic [QB-1:0] q,
                                                  input logic n);
    logic signed [VW-1:0] qs;
    qs = n ? -VW'(q) : VW'(q);
    return VW'(b) + qs;
  endfunction

  always_comb begin
    vx = place(id.bx, id.qx, id.nx);
    vy = place(id.by, id.qy, id.ny);
    sx = id.ox || (vx > MAXV) || (vx < MINV);
    sy = id.oy || (vy > MAXV) || (vy < MINV);
    if (id.ox)             cx_next = id.nx ? CW'(MINV) : CW'(MAXV);
    else if (vx > MAXV)    cx_next = CW'(MAXV);
    else if (vx < MINV)    cx_next = CW'(MINV);
    else                   cx_next = CW'(vx);
    if (id.oy)             cy_next = id.ny ? CW'(MINV) : CW'(MAXV);
    else if (vy > MAXV)    cy_next = CW'(MAXV);
    else if (vy < MINV)    cy_next = CW'(MINV);
    else                   cy_next = CW'(vy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= iv;
    end
  end

  // parallel lines force a zero result
  always_ff @(posedge clk) begin
    if (adv) begin
      cx  <= id.par ? '0 : cx_next;
      cy  <= id.par ? '0 : cy_next;
      hit <= id.hit && !id.par;
      par <= id.par;
      sat <= !id.par && (sx || sy);
    end
  end
endmodule

// File: rtl/segment_line_intersection_core.sv
// stages from request accepted to result valid: 5 front, 17 divider cells, 1 out
// throughput: one request per cycle while out_stall does not hold a full pipeline; each stage holds one request
// the chain of 17 division cells produces one quotient bit per cell for both coordinates
// a stalled output only holds stages that are full; empty stages keep accepting
// reset (rst, synchronous) empties all stages and sets segment_check to 1
module segment_line_intersection_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [slic_pkg::CW-1:0] p0_x,
  input  logic signed [slic_pkg::CW-1:0] p0_y,
  input  logic signed [slic_pkg::CW-1:0] p1_x,
  input  logic signed [slic_pkg::CW-1:0] p1_y,
  input  logic signed [slic_pkg::CW-1:0] p2_x,
  input  logic signed [slic_pkg::CW-1:0] p2_y,
  input  logic signed [slic_pkg::CW-1:0] p3_x,
  input  logic signed [slic_pkg::CW-1:0] p3_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [slic_pkg::CW-1:0] cross_x,
  output logic signed [slic_pkg::CW-1:0] cross_y,
  output logic                           hit,
  output logic                           parallel,
  output logic                           saturated
);
  import slic_pkg::*;
  `include "segment_line_intersection_core_macros.svh"

  logic segment_check;
  logic wr;

  logic       cv [QB+1];
  logic       cs [QB+1];
  slic_work_t cd [QB+1];

  // configuration register
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr[2] == ADDR_SEGMENT_CHECK)
              && (paddr[1:0] == 2'b00);
  assign prdata = (paddr[2] == ADDR_SEGMENT_CHECK) ? {31'b0, segment_check} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_check <= 1'b1;
    end else if (wr) begin
      segment_check <= pwdata[0];
    end
  end

  slic_front u_front (
    .clk(clk), .rst(rst), .seg_check(segment_check),
    .iv(in_valid), .istall(in_stall),
    .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
    .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
    .ov(cv[0]), .od(cd[0]), .ostall(cs[0])
  );

  // division chain, most significant quotient bit first
  for (genvar i = 0; i < QB; i++) begin : g_cell
    slic_cell u_cell (
      .clk(clk), .rst(rst), .k(KW'(QB - 1 - i)),
      .iv(cv[i]), .istall(cs[i]), .id(cd[i]),
      .ov(cv[i+1]), .od(cd[i+1]), .ostall(cs[i+1])
    );
  end

  slic_finish u_finish (
    .clk(clk), .rst(rst),
    .iv(cv[QB]), .istall(cs[QB]), .id(cd[QB]),
    .ov(out_valid), .cx(cross_x), .cy(cross_y),
    .hit(hit), .par(parallel), .sat(saturated),
    .ostall(out_stall)
  );

  `SLIC_ASSERT_NOW(a_par_zero, out_valid && parallel, (cross_x == '0) && (cross_y == '0) && !hit && !saturated, "parallel result not cleared")
  `SLIC_ASSERT_NEXT(a_cfg_write, wr, segment_check == $past(pwdata[0]), "segment_check not written")
  `SLIC_ASSERT_NOW(a_no_seg_hit, out_valid && !parallel && !segment_check, hit, "hit missing with segment test off")
  `SLIC_ASSERT_NOW(a_sat_edge, out_valid && saturated, (cross_x == {1'b0, {(CW-1){1'b1}}}) || (cross_x == {1'b1, {(CW-1){1'b0}}}) || (cross_y == {1'b0, {(CW-1){1'b1}}}) || (cross_y == {1'b1, {(CW-1){1'b0}}}), "saturated without a clamped coordinate")
endmodule
